/* rtl/core/bmt_pkg.sv */
// Shared codes, state encoding and command struct for the bidirectional map table.
package bmt_pkg;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;

  // Action codes carried by in_action
  localparam logic [ACTION_W-1:0] ACT_INSERT       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP_KEY   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP_VALUE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_KEY   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_VALUE = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_RESP  = 3'b100
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic resolve;
  } dp_cmd_t;

endpackage

/* rtl/core/bidirectional_map_table.sv */
// Top level of the bidirectional key/value map table.
//
// Usage:
//   Raise start with in_action, in_key and in_value; the command is taken at a
//   rising edge where start is high and busy is low. Actions: insert, lookup by
//   key, lookup by value, remove by key, remove by value.
//   Each command yields exactly one result transfer: out_strobe is high for one
//   cycle with out_status, out_key_out and out_value_out valid in that cycle.
//   The receiver has no way to stall; it must take the result when shown.
// Sequence:
//   Each command passes through capture, a parallel match over all entries,
//   and resolve with table update; out_strobe is registered on the resolve step.
//   busy stays high through the match and resolve states, so a new command is
//   taken only after the current one has been resolved.
// Reset:
//   rst_n is synchronous, active low; it empties the table (all valid bits
//   clear) and returns the controller to idle. No clearing pass is needed.
module bidirectional_map_table
  import bmt_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [FIELD_W-1:0]  in_key,
  input  logic [FIELD_W-1:0]  in_value,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [FIELD_W-1:0]  out_key_out,
  output logic [FIELD_W-1:0]  out_value_out
);

  dp_cmd_t cmd;

  // Sequence each command
  bmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  // Store pairs, match and produce results
  bmt_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_status    (out_status),
    .out_key_out   (out_key_out),
    .out_value_out (out_value_out)
  );

endmodule

/* rtl/core/bmt_ctrl.sv */
// Controller state machine that sequences capture, match and resolve of one command.
module bmt_ctrl
  import bmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd,
  output logic    out_strobe
);

  state_t state_r;
  state_t state_nxt;
  logic   strobe_r;

  // Advance one step per cycle once a command is taken
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_RESP);
    end
  end

  // Drive datapath commands and handshake
  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.match   = (state_r == S_MATCH);
  assign cmd.resolve = (state_r == S_RESP);
  assign out_strobe  = strobe_r;

  // Every accepted command yields its result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("result strobe missing after accepted command");

  // The result transfer only shows while the controller is idle again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // No command is taken while one is in flight
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.capture)
    else $error("capture while busy");

endmodule

/* rtl/core/bmt_datapath.sv */
// Datapath: entry storage, parallel key and value match, result and table update.
module bmt_datapath
  import bmt_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [FIELD_W-1:0]  in_key,
  input  logic [FIELD_W-1:0]  in_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [FIELD_W-1:0]  out_key_out,
  output logic [FIELD_W-1:0]  out_value_out
);

  localparam int IDX_W = $clog2(ENTRIES);

  // Operand widening / truncation to storage widths
  logic [KEY_BITS+FIELD_W-1:0]   in_key_wide;
  logic [VALUE_BITS+FIELD_W-1:0] in_value_wide;

  assign in_key_wide   = {{KEY_BITS{1'b0}}, in_key};
  assign in_value_wide = {{VALUE_BITS{1'b0}}, in_value};

  // Captured command
  logic [ACTION_W-1:0]   action_r;
  logic [KEY_BITS-1:0]   op_key_r;
  logic [VALUE_BITS-1:0] op_value_r;

  // Table storage
  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_store_r   [ENTRIES];
  logic [VALUE_BITS-1:0] value_store_r [ENTRIES];

  // Match results
  logic             key_hit_r,  key_hit_nxt;
  logic [IDX_W-1:0] key_idx_r,  key_idx_nxt;
  logic             val_hit_r,  val_hit_nxt;
  logic [IDX_W-1:0] val_idx_r,  val_idx_nxt;
  logic             free_hit_r, free_hit_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  // Result registers
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [FIELD_W-1:0]  key_out_r, key_out_nxt;
  logic [FIELD_W-1:0]  value_out_r, value_out_nxt;

  logic                  use_value;
  logic [IDX_W-1:0]      sel_idx;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;
  logic [KEY_BITS+FIELD_W-1:0]   res_key_wide;
  logic [VALUE_BITS+FIELD_W-1:0] res_value_wide;
  logic                  write_en;
  logic                  clear_en;

  // Match every entry; keep the lowest index of each kind
  always_comb begin
    key_hit_nxt  = 1'b0;
    key_idx_nxt  = '0;
    val_hit_nxt  = 1'b0;
    val_idx_nxt  = '0;
    free_hit_nxt = 1'b0;
    free_idx_nxt = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_store_r[i] == op_key_r)) begin
        key_hit_nxt = 1'b1;
        key_idx_nxt = IDX_W'(i);
      end
      if (valid_r[i] && (value_store_r[i] == op_value_r)) begin
        val_hit_nxt = 1'b1;
        val_idx_nxt = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_hit_nxt = 1'b1;
        free_idx_nxt = IDX_W'(i);
      end
    end
  end

  // Pick the entry whose pair is reported
  assign use_value = (action_r == ACT_LOOKUP_VALUE) || (action_r == ACT_REMOVE_VALUE) ||
                     ((action_r == ACT_INSERT) && !key_hit_r);
  assign sel_idx  = use_value ? val_idx_r : key_idx_r;
  assign rd_key   = key_store_r[sel_idx];
  assign rd_value = value_store_r[sel_idx];

  // Resolve the command from the registered match
  always_comb begin
    status_nxt = ST_MISS;
    res_key    = '0;
    res_value  = '0;
    write_en   = 1'b0;
    clear_en   = 1'b0;
    unique case (action_r)
      ACT_INSERT: begin
        priority if (key_hit_r || val_hit_r) begin
          status_nxt = ST_DUP;
          res_key    = rd_key;
          res_value  = rd_value;
        end else if (free_hit_r) begin
          status_nxt = ST_OK;
          res_key    = op_key_r;
          res_value  = op_value_r;
          write_en   = 1'b1;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      ACT_LOOKUP_KEY, ACT_REMOVE_KEY: begin
        if (key_hit_r) begin
          status_nxt = ST_OK;
          res_key    = rd_key;
          res_value  = rd_value;
          clear_en   = (action_r == ACT_REMOVE_KEY);
        end
      end
      ACT_LOOKUP_VALUE, ACT_REMOVE_VALUE: begin
        if (val_hit_r) begin
          status_nxt = ST_OK;
          res_key    = rd_key;
          res_value  = rd_value;
          clear_en   = (action_r == ACT_REMOVE_VALUE);
        end
      end
      default: status_nxt = ST_MISS;
    endcase
  end

  // Fit the reported pair to the 32-bit result fields
  assign res_key_wide   = {{FIELD_W{1'b0}}, res_key};
  assign res_value_wide = {{FIELD_W{1'b0}}, res_value};
  assign key_out_nxt    = res_key_wide[FIELD_W-1:0];
  assign value_out_nxt  = res_value_wide[FIELD_W-1:0];

  // Hold operands, match results and result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r   <= in_action;
      op_key_r   <= in_key_wide[KEY_BITS-1:0];
      op_value_r <= in_value_wide[VALUE_BITS-1:0];
    end
    if (cmd.match) begin
      key_hit_r  <= key_hit_nxt;
      key_idx_r  <= key_idx_nxt;
      val_hit_r  <= val_hit_nxt;
      val_idx_r  <= val_idx_nxt;
      free_hit_r <= free_hit_nxt;
      free_idx_r <= free_idx_nxt;
    end
    if (cmd.resolve) begin
      status_r    <= status_nxt;
      key_out_r   <= key_out_nxt;
      value_out_r <= value_out_nxt;
      if (write_en) begin
        key_store_r[free_idx_r]   <= op_key_r;
        value_store_r[free_idx_r] <= op_value_r;
      end
    end
  end

  // Set on insert, drop on remove, clear all at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.resolve) begin
      if (write_en) valid_r[free_idx_r] <= 1'b1;
      if (clear_en) valid_r[sel_idx]    <= 1'b0;
    end
  end

  assign out_status    = status_r;
  assign out_key_out   = key_out_r;
  assign out_value_out = value_out_r;

  // Occupancy moves by at most one entry per cycle
  a_occupancy_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) <= $past($countones(valid_r)) + 1) &&
                     ($countones(valid_r) + 1 >= $past($countones(valid_r))))
    else $error("occupancy changed by more than one entry");

  // A full status is only reported when every entry is in use
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resolve && (status_nxt == ST_FULL)) |-> (&valid_r))
    else $error("full status with a free entry");

  // A registered key hit still points at a live entry when resolved
  a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resolve && key_hit_r) |-> valid_r[key_idx_r])
    else $error("key hit on an empty entry");

endmodule

/* tb/tb_bidirectional_map_table.sv */
// Self-checking testbench for the bidirectional key/value map table.
`timescale 1ns / 100ps

module tb_bidirectional_map_table;
  import bmt_pkg::*;

  localparam int MAP_DEPTH   = 16;
  localparam int POOL_SIZE   = 20;
  localparam int RANDOM_CMDS = 1600;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;

  // Action codes the block does not define; it answers them with a miss
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

  // Stimulus mix per random phase
  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FIELD_W-1:0]  key;
    logic [FIELD_W-1:0]  value;
  } map_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  key;
    logic [FIELD_W-1:0]  value;
  } map_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] in_action = '0;
  logic [FIELD_W-1:0]  in_key = '0;
  logic [FIELD_W-1:0]  in_value = '0;
  logic                out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_key_out;
  logic [FIELD_W-1:0]  out_value_out;

  // Commands waiting to be driven and replies the table owes us
  map_cmd_t   cmd_backlog[$];
  map_reply_t replies_due[$];

  // Shadow copy of the table contents
  logic               shadow_valid[MAP_DEPTH];
  logic [FIELD_W-1:0] shadow_key[MAP_DEPTH];
  logic [FIELD_W-1:0] shadow_value[MAP_DEPTH];

  logic [FIELD_W-1:0] key_pool[POOL_SIZE];
  logic [FIELD_W-1:0] value_pool[POOL_SIZE];

  int cmds_queued = 0;
  int cmds_taken  = 0;
  int mismatches  = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int cycle_count = 0;

  bidirectional_map_table #(
    .ENTRIES   (MAP_DEPTH),
    .KEY_BITS  (FIELD_W),
    .VALUE_BITS(FIELD_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_key       (in_key),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_key_out  (out_key_out),
    .out_value_out(out_value_out)
  );

  always #5 clk = ~clk;

  function automatic int slot_of_key(logic [FIELD_W-1:0] k);
    for (int i = 0; i < MAP_DEPTH; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int slot_of_value(logic [FIELD_W-1:0] v);
    for (int i = 0; i < MAP_DEPTH; i++)
      if (shadow_valid[i] && shadow_value[i] == v) return i;
    return -1;
  endfunction

  // Apply one transfer to the shadow table and record the reply it owes
  task automatic table_apply(map_cmd_t cmd);
    int         hit;
    int         free_slot;
    map_reply_t reply;
    hit = -1;
    free_slot = -1;
    reply = '{status: ST_MISS, key: '0, value: '0};
    case (cmd.action)
      ACT_INSERT: begin
        hit = slot_of_key(cmd.key);
        if (hit < 0) hit = slot_of_value(cmd.value);
        for (int i = MAP_DEPTH - 1; i >= 0; i--)
          if (!shadow_valid[i]) free_slot = i;
        if (hit >= 0) begin
          reply = '{status: ST_DUP, key: shadow_key[hit], value: shadow_value[hit]};
        end else if (free_slot >= 0) begin
          shadow_valid[free_slot] = 1'b1;
          shadow_key[free_slot] = cmd.key;
          shadow_value[free_slot] = cmd.value;
          reply = '{status: ST_OK, key: cmd.key, value: cmd.value};
        end else begin
          reply.status = ST_FULL;
        end
      end
      ACT_LOOKUP_KEY, ACT_REMOVE_KEY, ACT_LOOKUP_VALUE, ACT_REMOVE_VALUE: begin
        if (cmd.action == ACT_LOOKUP_KEY || cmd.action == ACT_REMOVE_KEY)
          hit = slot_of_key(cmd.key);
        else
          hit = slot_of_value(cmd.value);
        if (hit >= 0) begin
          reply = '{status: ST_OK, key: shadow_key[hit], value: shadow_value[hit]};
          if (cmd.action == ACT_REMOVE_KEY || cmd.action == ACT_REMOVE_VALUE)
            shadow_valid[hit] = 1'b0;
        end
      end
      default: ;
    endcase
    replies_due.push_back(reply);
  endtask

  task automatic queue_cmd(logic [ACTION_W-1:0] act, logic [FIELD_W-1:0] k,
                           logic [FIELD_W-1:0] v);
    cmd_backlog.push_back('{action: act, key: k, value: v});
    cmds_queued++;
  endtask

  // Operand mix: mostly pool members so entries collide, plus corners and noise
  function automatic logic [FIELD_W-1:0] pick_operand(logic [FIELD_W-1:0] pool_pick);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return pool_pick;
    if (roll < 85) return $urandom;
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [FIELD_W-1:0] want,
                                 logic [FIELD_W-1:0] got);
    if (mismatches < REPORT_MAX)
      $display("mismatch at %0t: %s expected %h, got %h", $time, field, want, got);
    mismatches++;
  endtask

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin : driver
    logic took;
    took = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (took) begin
        table_apply('{action: in_action, key: in_key, value: in_value});
        cmds_taken++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      // hold an offered command until it is taken, then honor any gap
      if (start && !took) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        map_cmd_t nxt;
        nxt = cmd_backlog.pop_front();
        start <= 1'b1;
        in_action <= nxt.action;
        in_key <= nxt.key;
        in_value <= nxt.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe is a result transfer, checked against the oldest reply due
  always @(posedge clk) begin : monitor
    map_reply_t want;
    if (rst_n && out_strobe) begin
      if (replies_due.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result at %0t: status %0d key %h value %h",
                   $time, out_status, out_key_out, out_value_out);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", FIELD_W'(want.status), FIELD_W'(out_status));
        if (out_key_out !== want.key) report_mismatch("key_out", want.key, out_key_out);
        if (out_value_out !== want.value)
          report_mismatch("value_out", want.value, out_value_out);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_kind;
    int phase_len;
    int ins_pct;
    int roll;
    int j;
    int random_done;
    logic [ACTION_W-1:0] act;
    logic [FIELD_W-1:0]  k;
    logic [FIELD_W-1:0]  v;

    for (int i = 0; i < MAP_DEPTH; i++) shadow_valid[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      value_pool[i] = $urandom;
    end

    // Directed: empty table, extremes, duplicates, unknown action, full table
    queue_cmd(ACT_LOOKUP_KEY, '0, '0);
    queue_cmd(ACT_INSERT, '0, '1);
    queue_cmd(ACT_INSERT, '1, '0);
    queue_cmd(ACT_INSERT, '0, 32'h5);            // key already present
    queue_cmd(ACT_INSERT, 32'h7, '0);            // value already present
    queue_cmd(ACT_INSERT, '1, '1);               // both present, key match wins
    queue_cmd(ACT_LOOKUP_KEY, '1, '0);
    queue_cmd(ACT_LOOKUP_VALUE, '0, '1);
    queue_cmd(ACT_UNDEF_HI, '1, '1);
    for (int i = 1; i <= MAP_DEPTH - 2; i++)
      queue_cmd(ACT_INSERT, (FIELD_W'(i) << 28) | FIELD_W'(i), 32'hA5A5_0000 | FIELD_W'(i));
    queue_cmd(ACT_INSERT, 32'h1234_5678, 32'h8765_4321);   // table full
    queue_cmd(ACT_INSERT, '0, 32'h1);                      // duplicate wins over full
    queue_cmd(ACT_REMOVE_KEY, '0, '0);
    queue_cmd(ACT_REMOVE_VALUE, '1, '0);

    // Random phases, each chosen at random to fill, drain or mix the table
    random_done = 0;
    while (random_done < RANDOM_CMDS) begin
      phase_kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
      phase_len = $urandom_range(30, 90);
      ins_pct = (phase_kind == PHASE_FILL) ? 55 : (phase_kind == PHASE_DRAIN) ? 15 : 35;
      repeat (3) begin
        j = $urandom_range(0, POOL_SIZE - 1);
        key_pool[j] = $urandom;
        value_pool[j] = $urandom;
      end
      repeat (phase_len) begin
        j = $urandom_range(0, POOL_SIZE - 1);
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
          act = ACT_INSERT;
        end else if (roll < ins_pct + 25) begin
          act = $urandom_range(0, 1) ? ACT_LOOKUP_KEY : ACT_LOOKUP_VALUE;
        end else if (roll < ins_pct + 29) begin
          act = ACTION_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        end else begin
          act = $urandom_range(0, 1) ? ACT_REMOVE_KEY : ACT_REMOVE_VALUE;
        end
        // half the time use a matched pool pair so inserts can fill the table
        if ($urandom_range(0, 1)) begin
          k = key_pool[j];
          v = value_pool[j];
        end else begin
          k = pick_operand(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
          v = pick_operand(value_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
        queue_cmd(act, k, v);
        if (act <= ACT_REMOVE_VALUE) random_done++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all commands taken, all replies seen, then a short tail
    while (cmds_taken < cmds_queued) @(posedge clk);
    while (replies_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
